FILE: src/tslf_pkg.sv
package tslf_pkg;

   localparam int NUMBER_DIGITS = 6;
   localparam int MAX_RESULTS = NUMBER_DIGITS + 3;
   localparam int COUNT_W = $clog2(MAX_RESULTS + 1);
   localparam int BCD_W = 4 * NUMBER_DIGITS;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_ALL      = 3'd0,
      CSR_NUMBER_NONBLANK = 3'd1,
      CSR_SQUEEZE_BLANK   = 3'd2,
      CSR_MARK_ENDS       = 3'd3,
      CSR_SHOW_TABS       = 3'd4,
      CSR_SHOW_CONTROL    = 3'd5
   } csr_index_type;

   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_NL       = 8'd10;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_DOLLAR   = 8'd36;
   localparam logic [7:0] CH_ZERO     = 8'd48;
   localparam logic [7:0] CH_QUESTION = 8'd63;
   localparam logic [7:0] CH_I        = 8'd73;
   localparam logic [7:0] CH_CARET    = 8'd94;
   localparam logic [7:0] CH_DEL      = 8'd127;
   localparam logic [7:0] CTRL_LIMIT  = 8'd32;
   localparam logic [7:0] CTRL_OFFSET = 8'd64;

   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic mark_ends;
      logic show_tabs;
      logic show_control;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0]               count;
      logic [MAX_RESULTS-1:0][7:0]      bytes;
   } gen_type;

   function automatic logic bcd_ok(input logic [BCD_W-1:0] value);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (value[4*i +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

FILE: src/tslf_expand.sv
module tslf_expand (
   input  logic                        clock,
   input  logic                        reset,
   input  tslf_pkg::cfg_type           cfg,
   input  logic                        step,
   input  logic [7:0]                  in_byte,
   input  logic                        file_start,
   output tslf_pkg::gen_type           gen
);

   logic                               after_newline_ff;
   logic                               after_newline_in;
   logic [1:0]                         blank_run_ff;
   logic [1:0]                         blank_run_in;
   logic [tslf_pkg::BCD_W-1:0]         line_ff;
   logic [tslf_pkg::BCD_W-1:0]         line_in;
   logic [tslf_pkg::BCD_W-1:0]         line_bumped;

   logic                               an;
   logic [1:0]                         br;
   logic [1:0]                         br_next;
   logic                               is_nl;
   logic                               squeezed;
   logic                               numbered;
   logic [7:0]                         tail0;
   logic [7:0]                         tail1;
   logic [1:0]                         tail_cnt;
   logic [tslf_pkg::NUMBER_DIGITS-1:0] nz;
   logic [tslf_pkg::NUMBER_DIGITS-1:0] nine;
   logic [tslf_pkg::NUMBER_DIGITS-1:0] low_nines;
   logic [tslf_pkg::NUMBER_DIGITS-1:0][7:0] digit_char;

   always_comb begin
      an = file_start ? 1'b1 : after_newline_ff;
      br = file_start ? 2'd0 : blank_run_ff;
      is_nl = (in_byte == tslf_pkg::CH_NL);
      br_next = br;
      squeezed = 1'b0;
      if (cfg.squeeze_blank && an) begin
         if (is_nl) begin
            br_next = (br < 2'd2) ? br + 2'd1 : br;
            squeezed = (br_next >= 2'd2);
         end else begin
            br_next = 2'd0;
         end
      end
      numbered = is_nl ? (an && cfg.number_all && !cfg.number_nonblank)
                       : (an && (cfg.number_all || cfg.number_nonblank));
   end

   always_comb begin
      tail0 = in_byte;
      tail1 = 8'd0;
      tail_cnt = 2'd1;
      priority if (is_nl) begin
         if (cfg.mark_ends) begin
            tail0 = tslf_pkg::CH_DOLLAR;
            tail1 = tslf_pkg::CH_NL;
            tail_cnt = 2'd2;
         end
      end else if (in_byte == tslf_pkg::CH_TAB) begin
         if (cfg.show_tabs) begin
            tail0 = tslf_pkg::CH_CARET;
            tail1 = tslf_pkg::CH_I;
            tail_cnt = 2'd2;
         end
      end else if (cfg.show_control && in_byte < tslf_pkg::CTRL_LIMIT) begin
         tail0 = tslf_pkg::CH_CARET;
         tail1 = in_byte + tslf_pkg::CTRL_OFFSET;
         tail_cnt = 2'd2;
      end else if (cfg.show_control && in_byte == tslf_pkg::CH_DEL) begin
         tail0 = tslf_pkg::CH_CARET;
         tail1 = tslf_pkg::CH_QUESTION;
         tail_cnt = 2'd2;
      end else begin
         tail0 = in_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < tslf_pkg::NUMBER_DIGITS; i++) begin
         nz[i] = (line_ff[4*i +: 4] != 4'd0);
         nine[i] = (line_ff[4*i +: 4] == 4'd9);
      end
      for (int i = 0; i < tslf_pkg::NUMBER_DIGITS; i++) begin
         if ((i == 0) || ((nz >> i) != '0)) begin
            digit_char[i] = tslf_pkg::CH_ZERO + {4'd0, line_ff[4*i +: 4]};
         end else begin
            digit_char[i] = tslf_pkg::CH_SPACE;
         end
      end
      low_nines[0] = 1'b1;
      for (int i = 1; i < tslf_pkg::NUMBER_DIGITS; i++) begin
         low_nines[i] = low_nines[i-1] & nine[i-1];
      end
      line_bumped = line_ff;
      if (!(&nine)) begin
         for (int i = 0; i < tslf_pkg::NUMBER_DIGITS; i++) begin
            if (low_nines[i]) begin
               line_bumped[4*i +: 4] = nine[i] ? 4'd0 : line_ff[4*i +: 4] + 4'd1;
            end
         end
      end
   end

   always_comb begin
      gen.bytes = '0;
      if (numbered) begin
         for (int i = 0; i < tslf_pkg::NUMBER_DIGITS; i++) begin
            gen.bytes[tslf_pkg::NUMBER_DIGITS-1-i] = digit_char[i];
         end
         gen.bytes[tslf_pkg::NUMBER_DIGITS] = tslf_pkg::CH_TAB;
         gen.bytes[tslf_pkg::NUMBER_DIGITS+1] = tail0;
         gen.bytes[tslf_pkg::NUMBER_DIGITS+2] = tail1;
         gen.count = tslf_pkg::COUNT_W'(tslf_pkg::NUMBER_DIGITS + 1)
                     + tslf_pkg::COUNT_W'(tail_cnt);
      end else begin
         gen.bytes[0] = tail0;
         gen.bytes[1] = tail1;
         gen.count = tslf_pkg::COUNT_W'(tail_cnt);
      end
      if (squeezed) begin
         gen.count = '0;
      end
   end

   always_comb begin
      after_newline_in = after_newline_ff;
      blank_run_in = blank_run_ff;
      line_in = line_ff;
      if (step) begin
         after_newline_in = squeezed ? an : is_nl;
         blank_run_in = br_next;
         if (numbered && !squeezed) begin
            line_in = line_bumped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_newline_ff <= 1'b1;
         blank_run_ff <= 2'd0;
         line_ff <= tslf_pkg::BCD_W'(1);
      end else begin
         after_newline_ff <= after_newline_in;
         blank_run_ff <= blank_run_in;
         line_ff <= line_in;
      end
   end

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      tslf_pkg::bcd_ok(line_ff))
      else $error("Line counter holds a digit above nine.");

   a_blank_run_range: assert property (@(posedge clock) disable iff (reset)
      blank_run_ff != 2'd3)
      else $error("Blank line run count went past two.");

   a_counter_moves_by_one_line: assert property (@(posedge clock) disable iff (reset)
      (step && !(numbered && !squeezed)) |=> $stable(line_ff))
      else $error("Line counter changed on an unnumbered request.");

endmodule

FILE: src/tslf_outbuf.sv
module tslf_outbuf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  tslf_pkg::gen_type           gen,
   output logic                        free,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_group
);

   logic [tslf_pkg::COUNT_W-1:0]                 count_ff;
   logic [tslf_pkg::COUNT_W-1:0]                 count_in;
   logic [tslf_pkg::MAX_RESULTS-1:0][7:0]        bytes_ff;
   logic [tslf_pkg::MAX_RESULTS-1:0][7:0]        bytes_in;

   assign rsp_valid = (count_ff != '0);
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_last_of_group = (count_ff == tslf_pkg::COUNT_W'(1));
   assign free = (count_ff == '0) || (rsp_last_of_group && rsp_ready);

   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (load) begin
         count_in = gen.count;
         bytes_in = gen.bytes;
      end else if (rsp_valid && rsp_ready) begin
         count_in = count_ff - tslf_pkg::COUNT_W'(1);
         for (int k = 0; k < tslf_pkg::MAX_RESULTS - 1; k++) begin
            bytes_in[k] = bytes_ff[k+1];
         end
         bytes_in[tslf_pkg::MAX_RESULTS-1] = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      bytes_ff <= bytes_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("Output buffer loaded while results were still pending.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tslf_pkg::COUNT_W'(tslf_pkg::MAX_RESULTS))
      else $error("Output buffer count out of range.");

   a_drain_by_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !load) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("Output buffer did not advance by one result.");

endmodule

FILE: src/text_stream_line_filter.sv
// The first result of a request is presented once the request has passed the input register
// and been loaded into the output buffer; the load waits while the buffer still holds results.
// Throughput: one request per cycle while each request yields at most one result and rsp_ready
// stays high; a request that yields several results holds the output buffer until its shift-out
// has passed the last result, and one that yields none passes through without loading it.
// Reset clears all options, marks the stream as just after a newline, zeroes the blank line
// run, sets the line counter to one and empties the pipeline.
module text_stream_line_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_file_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last_of_group,
   input  logic                               csr_we,
   input  logic [tslf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic                               csr_wdata
);

   tslf_pkg::cfg_type   cfg_ff;
   tslf_pkg::cfg_type   cfg_in;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_start_ff;
   tslf_pkg::gen_type   gen;
   logic                buf_free;
   logic                advance;
   logic                load;
   logic                req_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tslf_pkg::CSR_NUMBER_ALL:      cfg_in.number_all = csr_wdata;
            tslf_pkg::CSR_NUMBER_NONBLANK: cfg_in.number_nonblank = csr_wdata;
            tslf_pkg::CSR_SQUEEZE_BLANK:   cfg_in.squeeze_blank = csr_wdata;
            tslf_pkg::CSR_MARK_ENDS:       cfg_in.mark_ends = csr_wdata;
            tslf_pkg::CSR_SHOW_TABS:       cfg_in.show_tabs = csr_wdata;
            tslf_pkg::CSR_SHOW_CONTROL:    cfg_in.show_control = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance = in_valid_ff && (buf_free || (gen.count == '0));
   assign load = advance && (gen.count != '0);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_start_ff <= req_file_start;
      end
   end

   tslf_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .file_start (in_start_ff),
      .gen        (gen)
   );

   tslf_outbuf u_outbuf (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .gen               (gen),
      .free              (buf_free),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_group (rsp_last_of_group)
   );

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_start_ff)))
      else $error("A held request was lost or changed.");

   a_empty_request_passes: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && gen.count == '0) |-> advance)
      else $error("A request without results was stalled.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("Input stage empty but not ready.");

endmodule
